@@ hw/rtl/tspd_pkg.sv @@
package tspd_pkg;

	// Default build of the three filter stages
	localparam int RING_DEPTH_DEF    = 512;
	localparam int STAGE1_UP_DEF     = 4;
	localparam int STAGE1_DOWN_DEF   = 3;
	localparam int HALFBAND_DOWN_DEF = 2;

	// Field widths
	localparam int CMD_W    = 2;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int COEF_AW  = 9;
	localparam int TAPS_W   = 10;
	localparam int RING_W   = 24;
	localparam int FRAC_W   = 8;
	localparam int PROD_W   = RING_W + COEF_W;
	localparam int ACC_W    = 52;
	localparam int RND_SH   = 16;
	localparam int RND_W    = ACC_W - RND_SH;

	// Coefficient store size and largest usable tap count
	localparam int COEF_DEPTH = 512;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE        = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_FIRST    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_HALFBAND = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED        = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS_FIRST    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS_HALFBAND = 1'b1;

endpackage

@@ hw/rtl/tspd_if.sv @@
interface tspd_in_if;
	logic                                    valid;
	logic                                    ready;
	logic [tspd_pkg::CMD_W-1:0]              cmd;
	logic signed [tspd_pkg::SAMPLE_W-1:0]    sample_in;
	logic [tspd_pkg::COEF_AW-1:0]            coef_index;
	logic signed [tspd_pkg::COEF_W-1:0]      coef_value;

	modport source (output valid, cmd, sample_in, coef_index, coef_value, input ready);
	modport sink (input valid, cmd, sample_in, coef_index, coef_value, output ready);
endinterface

interface tspd_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [tspd_pkg::SAMPLE_W-1:0]    sample_out;
	logic                                    clipped;

	modport source (output valid, sample_out, clipped, input ready);
	modport sink (input valid, sample_out, clipped, output ready);
endinterface

interface tspd_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic [tspd_pkg::CFG_IDX_W-1:0]          index;
	logic [tspd_pkg::TAPS_W-1:0]             data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tspd_ram.sv @@
module tspd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/three_stage_polyphase_downsampler.sv @@
// Three-stage polyphase downsampler, 48 kHz in, 16 kHz out.
// in_ch carries samples (cmd sample), coefficient loads for the first-stage or
// the shared halfband store, and unused commands, which are ignored. Loads give
// no result. A sample runs through up-4/down-3, down-2, down-2.
// out_ch delivers one 16-bit sample plus a clip flag for about every third
// input sample. cfg_ch writes the two tap counts; it is always ready. The user
// must write it only while the block is idle; the block does not enforce this.
// Datapath: all filter arithmetic goes through one 24x18 multiplier and one
// accumulator under a small sequencer, one tap per cycle. A sample item is pushed
// into the first ring; each filter output it causes is accumulated, rounded and
// stored, and each value passed on is pushed into the next stage's ring.
// in_ch.ready is low while a sample is being worked on.
// Reset: the three delay rings are cleared one entry per cycle, all RING_DEPTH
// entries (512 by default), before in_ch.ready first rises; coefficient stores
// are not cleared and must be loaded before use.
// A stalled receiver holds the result in the output register; the sequencer
// keeps working and waits only when it has a second result ready.
module three_stage_polyphase_downsampler #(
	parameter int RING_DEPTH    = tspd_pkg::RING_DEPTH_DEF,
	parameter int STAGE1_UP     = tspd_pkg::STAGE1_UP_DEF,
	parameter int STAGE1_DOWN   = tspd_pkg::STAGE1_DOWN_DEF,
	parameter int HALFBAND_DOWN = tspd_pkg::HALFBAND_DOWN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tspd_in_if.sink           in_ch,
	tspd_out_if.source        out_ch,
	tspd_cfg_if.sink          cfg_ch
);

	localparam int RW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int MAXD    = (STAGE1_DOWN > HALFBAND_DOWN) ? STAGE1_DOWN : HALFBAND_DOWN;
	localparam int PW      = $clog2(MAXD + 1);
	localparam int IW      = (STAGE1_UP > 1) ? $clog2(STAGE1_UP) : 1;
	localparam int KW      = tspd_pkg::TAPS_W;
	localparam int SKW     = tspd_pkg::COEF_AW;
	localparam int SKIP_SH = 20;
	localparam int REC_W   = SKIP_SH + 1;
	localparam int REC_FIRST = ((1 << SKIP_SH) + 2 * STAGE1_DOWN - 1) / (2 * STAGE1_DOWN);
	localparam int REC_HB    = ((1 << SKIP_SH) + 2 * HALFBAND_DOWN - 1) / (2 * HALFBAND_DOWN);
	localparam int SPW     = SKW + REC_W;
	localparam int ACC_W   = tspd_pkg::ACC_W;
	localparam int PROD_W  = tspd_pkg::PROD_W;
	localparam int RND_W   = tspd_pkg::RND_W;
	localparam int RING_W  = tspd_pkg::RING_W;
	localparam int SMP_W   = tspd_pkg::SAMPLE_W;
	localparam int FL_W    = RND_W - tspd_pkg::FRAC_W;

	localparam logic [1:0] STG_FIRST = 2'd0;
	localparam logic [1:0] STG_LAST  = 2'd2;

	localparam logic signed [RND_W-1:0] R24_MAX = RND_W'((1 << (RING_W - 1)) - 1);
	localparam logic signed [RND_W-1:0] R24_MIN = -RND_W'(1 << (RING_W - 1));
	localparam logic signed [FL_W-1:0]  S16_MAX = FL_W'((1 << (SMP_W - 1)) - 1);
	localparam logic signed [FL_W-1:0]  S16_MIN = -FL_W'(1 << (SMP_W - 1));

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_PUSH  = 8'b0000_0100,
		S_FIRE  = 8'b0000_1000,
		S_MAC   = 8'b0001_0000,
		S_ROUND = 8'b0010_0000,
		S_STORE = 8'b0100_0000,
		S_NEXT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic               emit_q;
	logic [RW-1:0]      clr_q;
	logic [RW-1:0]      head_q [3];
	logic [PW-1:0]      phase_q [3];
	logic [SKW-1:0]     skip_q [3];
	logic [KW-1:0]      taps_first_q;
	logic [KW-1:0]      taps_hb_q;
	logic [1:0]         stage_q;
	logic [IW-1:0]      i_q;
	logic               emitted_q;
	logic               out_valid_q;
	logic               iss_s1;
	logic               mul_v_s2;

	logic [RING_W-1:0]        push_val_q;
	logic [KW-1:0]            k_q;
	logic [RW-1:0]            l_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [RND_W-1:0]  rnd_q;
	logic [SMP_W-1:0]         out_sample_q;
	logic                     out_clip_q;

	logic                ring_we [3];
	logic [RW-1:0]       ring_wa [3];
	logic [RING_W-1:0]   ring_wd [3];
	logic [RING_W-1:0]   ring_rd [3];
	logic [tspd_pkg::COEF_W-1:0] fc_rd;
	logic [tspd_pkg::COEF_W-1:0] hc_rd;

	logic                in_acc;
	logic [RW-1:0]       head_new;
	logic [KW-1:0]       taps_sel;
	logic [KW-1:0]       teff;
	logic                issue;
	logic [KW-1:0]       k_step;
	logic [PW-1:0]       ph_dec;
	logic [PW-1:0]       down_sel;
	logic                fires;
	logic                mac_done;
	logic                last_phase;
	logic [RW-1:0]       l_inc;
	logic signed [ACC_W-1:0] acc_rnd;
	logic [RING_W-1:0]   sat24;
	logic signed [FL_W-1:0]  fl;
	logic signed [FL_W-1:0]  tr;
	logic [SMP_W-1:0]    fin_sample;
	logic                fin_clip;
	logic [KW-1:0]       cfg_eff;
	logic [SKW-1:0]      cfg_x;
	logic [SPW-1:0]      skip_p_first;
	logic [SPW-1:0]      skip_p_hb;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.clipped = out_clip_q;

	// Ring pointer and tap walk arithmetic
	always_comb begin
		head_new = (head_q[stage_q] == '0) ? RW'(RING_DEPTH - 1) : head_q[stage_q] - 1'b1;
		l_inc = (l_q == RW'(RING_DEPTH - 1)) ? '0 : l_q + 1'b1;
		taps_sel = (stage_q == STG_FIRST) ? taps_first_q : taps_hb_q;
		teff = (taps_sel > KW'(tspd_pkg::COEF_DEPTH)) ? KW'(tspd_pkg::COEF_DEPTH) : taps_sel;
		issue = (k_q < teff);
		k_step = (stage_q == STG_FIRST) ? KW'(STAGE1_UP) : KW'(1);
		down_sel = (stage_q == STG_FIRST) ? PW'(STAGE1_DOWN) : PW'(HALFBAND_DOWN);
		ph_dec = phase_q[stage_q] - 1'b1;
		fires = (ph_dec == '0);
		mac_done = !issue && !iss_s1 && !mul_v_s2;
		last_phase = (i_q == IW'(STAGE1_UP - 1));
	end

	// Round to Q16.8, then saturate for the next ring or finish the output
	always_comb begin
		acc_rnd = acc_q + ACC_W'(1 << (tspd_pkg::RND_SH - 1));
		if (rnd_q > R24_MAX) begin
			sat24 = R24_MAX[RING_W-1:0];
		end else if (rnd_q < R24_MIN) begin
			sat24 = R24_MIN[RING_W-1:0];
		end else begin
			sat24 = rnd_q[RING_W-1:0];
		end
		fl = FL_W'(rnd_q >>> tspd_pkg::FRAC_W);
		tr = fl + FL_W'(rnd_q[RND_W-1] && (rnd_q[tspd_pkg::FRAC_W-1:0] != '0));
		fin_clip = (tr > S16_MAX) || (tr < S16_MIN);
		if (tr > S16_MAX) begin
			fin_sample = S16_MAX[SMP_W-1:0];
		end else if (tr < S16_MIN) begin
			fin_sample = S16_MIN[SMP_W-1:0];
		end else begin
			fin_sample = tr[SMP_W-1:0];
		end
	end

	// Start-up skip from a written tap count: floor((taps-1)/(2*down))
	always_comb begin
		cfg_eff = (cfg_ch.data > KW'(tspd_pkg::COEF_DEPTH)) ? KW'(tspd_pkg::COEF_DEPTH)
			: cfg_ch.data;
		cfg_x = (cfg_eff == '0) ? '0 : SKW'(cfg_eff - 1'b1);
		skip_p_first = SPW'(cfg_x) * SPW'(REC_FIRST);
		skip_p_hb = SPW'(cfg_x) * SPW'(REC_HB);
	end

	// Ring write ports: clearing pass, or a push into the active stage
	always_comb begin
		for (int s = 0; s < 3; s++) begin
			ring_we[s] = 1'b0;
			ring_wa[s] = head_new;
			ring_wd[s] = push_val_q;
			if (state_q == S_CLEAR) begin
				ring_we[s] = 1'b1;
				ring_wa[s] = clr_q;
				ring_wd[s] = '0;
			end else if (state_q == S_PUSH && stage_q == 2'(s)) begin
				ring_we[s] = 1'b1;
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_ring
		tspd_ram #(.WIDTH(RING_W), .DEPTH(RING_DEPTH), .AW(RW)) u_ring (
			.clk   (clk),
			.we    (ring_we[g]),
			.waddr (ring_wa[g]),
			.wdata (ring_wd[g]),
			.raddr (l_q),
			.rdata (ring_rd[g])
		);
	end

	tspd_ram #(.WIDTH(tspd_pkg::COEF_W), .DEPTH(tspd_pkg::COEF_DEPTH),
		.AW(tspd_pkg::COEF_AW)) u_first_coefs (
		.clk   (clk),
		.we    (in_acc && in_ch.cmd == tspd_pkg::CMD_LOAD_FIRST),
		.waddr (in_ch.coef_index),
		.wdata (in_ch.coef_value),
		.raddr (k_q[tspd_pkg::COEF_AW-1:0]),
		.rdata (fc_rd)
	);

	tspd_ram #(.WIDTH(tspd_pkg::COEF_W), .DEPTH(tspd_pkg::COEF_DEPTH),
		.AW(tspd_pkg::COEF_AW)) u_hb_coefs (
		.clk   (clk),
		.we    (in_acc && in_ch.cmd == tspd_pkg::CMD_LOAD_HALFBAND),
		.waddr (in_ch.coef_index),
		.wdata (in_ch.coef_value),
		.raddr (k_q[tspd_pkg::COEF_AW-1:0]),
		.rdata (hc_rd)
	);

	assign emit_q = (state_q == S_STORE) && (skip_q[stage_q] == '0) && (stage_q == STG_LAST)
		&& !emitted_q;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			for (int s = 0; s < 3; s++) begin
				head_q[s] <= '0;
				phase_q[s] <= PW'(1);
				skip_q[s] <= '0;
			end
			taps_first_q <= KW'(1);
			taps_hb_q <= KW'(1);
			stage_q <= STG_FIRST;
			i_q <= '0;
			emitted_q <= 1'b0;
			out_valid_q <= 1'b0;
			iss_s1 <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			iss_s1 <= (state_q == S_MAC) && issue;
			mul_v_s2 <= iss_s1;
			// Load a new result, or drop the one the receiver took
			if (emit_q && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == RW'(RING_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && in_ch.cmd == tspd_pkg::CMD_SAMPLE) begin
						stage_q <= STG_FIRST;
						i_q <= '0;
						emitted_q <= 1'b0;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					head_q[stage_q] <= head_new;
					state_q <= S_FIRE;
				end
				S_FIRE: begin
					phase_q[stage_q] <= fires ? down_sel : ph_dec;
					state_q <= fires ? S_MAC : S_NEXT;
				end
				S_MAC: begin
					if (mac_done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= S_STORE;
				end
				S_STORE: begin
					if (skip_q[stage_q] != '0) begin
						skip_q[stage_q] <= skip_q[stage_q] - 1'b1;
						state_q <= S_NEXT;
					end else if (stage_q != STG_LAST) begin
						stage_q <= stage_q + 1'b1;
						state_q <= S_PUSH;
					end else if (emitted_q) begin
						state_q <= S_NEXT;
					end else if (!out_valid_q || out_ch.ready) begin
						emitted_q <= 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					stage_q <= STG_FIRST;
					if (last_phase) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_FIRE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Tap count writes recompute the start-up skips
			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					tspd_pkg::REG_TAPS_FIRST: begin
						taps_first_q <= cfg_ch.data;
						skip_q[0] <= skip_p_first[SKIP_SH +: SKW];
					end
					tspd_pkg::REG_TAPS_HALFBAND: begin
						taps_hb_q <= cfg_ch.data;
						skip_q[1] <= skip_p_hb[SKIP_SH +: SKW];
						skip_q[2] <= skip_p_hb[SKIP_SH +: SKW];
					end
					default: begin
						taps_hb_q <= taps_hb_q;
					end
				endcase
			end
		end
	end

	// Datapath: one multiply-accumulate per tap, rounding, output register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			push_val_q <= {in_ch.sample_in, {tspd_pkg::FRAC_W{1'b0}}};
		end
		if (state_q == S_FIRE) begin
			k_q <= (stage_q == STG_FIRST) ? KW'(i_q) : '0;
			l_q <= head_q[stage_q];
			acc_q <= '0;
		end
		if (state_q == S_MAC && issue) begin
			k_q <= k_q + k_step;
			l_q <= l_inc;
		end
		prod_s2 <= $signed(ring_rd[stage_q]) * $signed((stage_q == STG_FIRST) ? fc_rd : hc_rd);
		if (mul_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (state_q == S_ROUND) begin
			rnd_q <= RND_W'(acc_rnd >>> tspd_pkg::RND_SH);
		end
		if (state_q == S_STORE) begin
			push_val_q <= sat24;
		end
		if (emit_q && (!out_valid_q || out_ch.ready)) begin
			out_sample_q <= fin_sample;
			out_clip_q <= fin_clip;
		end
	end

endmodule

@@ hw/rtl/tspd_checker.sv @@
module tspd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [tspd_pkg::CMD_W-1:0]     in_cmd,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [tspd_pkg::SAMPLE_W-1:0]  out_sample,
	input logic                           out_clipped,
	input logic                           cfg_ready
);

	// Ready drops in the cycle after a sample item is accepted
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == tspd_pkg::CMD_SAMPLE |=> !in_ready)
		else $error("ready stayed high after a sample item");

	// Loads and unused commands leave the block idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd != tspd_pkg::CMD_SAMPLE |=> in_ready)
		else $error("ready dropped after a non-sample item");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clipped))
		else $error("stalled result changed");

	// A clipped result sits on a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_clipped |-> out_sample == 16'h7FFF || out_sample == 16'h8000)
		else $error("clip flag on a value off the rails");

	// The configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind three_stage_polyphase_downsampler tspd_checker u_tspd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_cmd      (in_ch.cmd),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_sample  (out_ch.sample_out),
	.out_clipped (out_ch.clipped),
	.cfg_ready   (cfg_ch.ready)
);

@@ tb/sv/tb_three_stage_polyphase_downsampler.sv @@
`timescale 1ns / 1ps

typedef struct packed {
	logic signed [tspd_pkg::SAMPLE_W-1:0] pcm;
	logic                                 clip;
} pcm_out_t;

// Tracks the three filter stages and the 16 kHz samples they should produce
class downsample_predictor;
	logic signed [tspd_pkg::RING_W-1:0] ring [3][tspd_pkg::RING_DEPTH_DEF];
	logic signed [tspd_pkg::COEF_W-1:0] first_c [tspd_pkg::COEF_DEPTH];
	logic signed [tspd_pkg::COEF_W-1:0] half_c [tspd_pkg::COEF_DEPTH];
	int unsigned head [3];
	int unsigned phase [3];
	int unsigned skip [3];
	int unsigned taps_first;
	int unsigned taps_half;
	pcm_out_t expected_pcm [$];
	bit got_one;
	int errors;
	int results;
	int clips;
	int samples;

	function new();
		for (int s = 0; s < 3; s++) begin
			for (int i = 0; i < tspd_pkg::RING_DEPTH_DEF; i++) ring[s][i] = '0;
			head[s] = 0;
			phase[s] = 1;
		end
		for (int i = 0; i < tspd_pkg::COEF_DEPTH; i++) begin
			first_c[i] = '0;
			half_c[i] = '0;
		end
		errors = 0;
		results = 0;
		clips = 0;
		samples = 0;
		set_taps(tspd_pkg::REG_TAPS_FIRST, 1);
		set_taps(tspd_pkg::REG_TAPS_HALFBAND, 1);
	endfunction

	function int unsigned eff(int unsigned t);
		return (t > tspd_pkg::COEF_DEPTH) ? tspd_pkg::COEF_DEPTH : t;
	endfunction

	function int unsigned skip_of(int unsigned t, int unsigned down);
		int unsigned e;
		e = eff(t);
		return (e == 0) ? 0 : (e - 1) / (2 * down);
	endfunction

	// Recompute the start-up skips of the stages that use the register
	function void set_taps(logic [tspd_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
		if (idx == tspd_pkg::REG_TAPS_FIRST) begin
			taps_first = v;
			skip[0] = skip_of(v, tspd_pkg::STAGE1_DOWN_DEF);
		end else begin
			taps_half = v;
			skip[1] = skip_of(v, tspd_pkg::HALFBAND_DOWN_DEF);
			skip[2] = skip_of(v, tspd_pkg::HALFBAND_DOWN_DEF);
		end
	endfunction

	function void push(int s, logic signed [tspd_pkg::RING_W-1:0] v);
		head[s] = (head[s] + tspd_pkg::RING_DEPTH_DEF - 1) % tspd_pkg::RING_DEPTH_DEF;
		ring[s][head[s]] = v;
	endfunction

	function longint mac(int s, int unsigned os, int unsigned up);
		longint acc;
		int unsigned l;
		int unsigned t;
		acc = 0;
		l = head[s];
		t = eff(s == 0 ? taps_first : taps_half);
		for (int unsigned k = os; k < t; k += up) begin
			acc += longint'(ring[s][l]) * longint'(s == 0 ? first_c[k] : half_c[k]);
			l = (l + 1) % tspd_pkg::RING_DEPTH_DEF;
		end
		return acc;
	endfunction

	function bit fires(int s, int unsigned down);
		phase[s]--;
		if (phase[s] == 0) begin
			phase[s] = down;
			return 1;
		end
		return 0;
	endfunction

	function bit passes(int s);
		if (skip[s] > 0) begin
			skip[s]--;
			return 0;
		end
		return 1;
	endfunction

	// Round Q.24 to Q16.8, saturate to ring width
	function logic signed [tspd_pkg::RING_W-1:0] to_ring(longint acc);
		longint r;
		r = (acc + 32768) >>> 16;
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[tspd_pkg::RING_W-1:0];
	endfunction

	function void emit(longint acc);
		longint q;
		longint iv;
		pcm_out_t o;
		q = (acc + 32768) >>> 16;
		iv = q / 256;
		o.clip = 1'b0;
		if (iv > 32767) begin
			iv = 32767;
			o.clip = 1'b1;
		end
		if (iv < -32768) begin
			iv = -32768;
			o.clip = 1'b1;
		end
		o.pcm = iv[tspd_pkg::SAMPLE_W-1:0];
		if (!got_one) expected_pcm.push_back(o);
		got_one = 1;
	endfunction

	function void stage_three(logic signed [tspd_pkg::RING_W-1:0] v);
		longint acc;
		push(2, v);
		if (fires(2, tspd_pkg::HALFBAND_DOWN_DEF)) begin
			acc = mac(2, 0, 1);
			if (passes(2)) emit(acc);
		end
	endfunction

	function void stage_two(logic signed [tspd_pkg::RING_W-1:0] v);
		longint acc;
		push(1, v);
		if (fires(1, tspd_pkg::HALFBAND_DOWN_DEF)) begin
			acc = mac(1, 0, 1);
			if (passes(1)) stage_three(to_ring(acc));
		end
	endfunction

	// Note an accepted input item
	function void note_item(logic [tspd_pkg::CMD_W-1:0] cmd,
			logic signed [tspd_pkg::SAMPLE_W-1:0] s,
			logic [tspd_pkg::COEF_AW-1:0] idx, logic signed [tspd_pkg::COEF_W-1:0] val);
		longint acc;
		if (cmd == tspd_pkg::CMD_LOAD_FIRST) begin
			first_c[idx] = val;
		end else if (cmd == tspd_pkg::CMD_LOAD_HALFBAND) begin
			half_c[idx] = val;
		end else if (cmd == tspd_pkg::CMD_SAMPLE) begin
			samples++;
			got_one = 0;
			push(0, {s, 8'h00});
			for (int unsigned i = 0; i < tspd_pkg::STAGE1_UP_DEF; i++) begin
				if (fires(0, tspd_pkg::STAGE1_DOWN_DEF)) begin
					acc = mac(0, i, tspd_pkg::STAGE1_UP_DEF);
					if (passes(0)) stage_two(to_ring(acc));
				end
			end
		end
	endfunction

	// Check one delivered sample against the oldest expectation
	function void check_result(logic signed [tspd_pkg::SAMPLE_W-1:0] pcm, logic clip);
		pcm_out_t e;
		results++;
		if (expected_pcm.size() == 0) begin
			$error("unexpected output item: sample_out %0d clipped %0b", pcm, clip);
			errors++;
			return;
		end
		e = expected_pcm.pop_front();
		if (clip) clips++;
		if (pcm !== e.pcm) begin
			$error("sample_out: expected %0d, got %0d", e.pcm, pcm);
			errors++;
		end
		if (clip !== e.clip) begin
			$error("clipped: expected %0b, got %0b", e.clip, clip);
			errors++;
		end
	endfunction
endclass

module tb_three_stage_polyphase_downsampler;
	logic clk;
	logic arst_n;
	int send_idle_pct;
	int recv_stall_pct;

	tspd_in_if in_ch ();
	tspd_out_if out_ch ();
	tspd_cfg_if cfg_ch ();

	downsample_predictor board;

	three_stage_polyphase_downsampler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall at random, check each delivered item
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_result(out_ch.sample_out, out_ch.clipped);
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hand one item to the block, with random idle cycles ahead of it
	task automatic send_item(logic [tspd_pkg::CMD_W-1:0] cmd,
			logic signed [tspd_pkg::SAMPLE_W-1:0] s,
			logic [tspd_pkg::COEF_AW-1:0] idx, logic signed [tspd_pkg::COEF_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.sample_in <= s;
		in_ch.coef_index <= idx;
		in_ch.coef_value <= val;
		do @(posedge clk); while (!in_ch.ready);
		board.note_item(cmd, s, idx, val);
	endtask

	task automatic hold_input();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every expected item has come, then let a sample finish
	task automatic drain();
		hold_input();
		while (board.expected_pcm.size() != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	task automatic write_taps(logic [tspd_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v[tspd_pkg::TAPS_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		board.set_taps(idx, v);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Set both tap counts and load every coefficient they reach
	task automatic setup_phase(int unsigned tf, int unsigned th);
		drain();
		write_taps(tspd_pkg::REG_TAPS_FIRST, tf);
		write_taps(tspd_pkg::REG_TAPS_HALFBAND, th);
		for (int i = 0; i < board.eff(tf); i++)
			send_item(tspd_pkg::CMD_LOAD_FIRST, '0, i[tspd_pkg::COEF_AW-1:0],
				tspd_pkg::COEF_W'($urandom));
		for (int i = 0; i < board.eff(th); i++)
			send_item(tspd_pkg::CMD_LOAD_HALFBAND, '0, i[tspd_pkg::COEF_AW-1:0],
				tspd_pkg::COEF_W'($urandom));
	endtask

	function automatic logic signed [tspd_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1: return $signed(16'($urandom_range(255))) - 16'sd128;
			default: return tspd_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// Mostly samples, some coefficient reloads, a little unused-command noise
	task automatic random_samples(int n, bit pause_midway);
		int done;
		int r;
		done = 0;
		while (done < n) begin
			r = $urandom_range(99);
			if (r < 75) begin
				send_item(tspd_pkg::CMD_SAMPLE, pick_sample(),
					tspd_pkg::COEF_AW'($urandom), tspd_pkg::COEF_W'($urandom));
				done++;
				if (pause_midway && done == n / 2) begin
					hold_input();
					while (board.expected_pcm.size() != 0) @(posedge clk);
				end
			end else if (r < 90) begin
				send_item($urandom_range(1) ? tspd_pkg::CMD_LOAD_FIRST
					: tspd_pkg::CMD_LOAD_HALFBAND, tspd_pkg::SAMPLE_W'($urandom),
					tspd_pkg::COEF_AW'($urandom), tspd_pkg::COEF_W'($urandom));
			end else begin
				send_item(tspd_pkg::CMD_UNUSED, tspd_pkg::SAMPLE_W'($urandom),
					tspd_pkg::COEF_AW'($urandom), tspd_pkg::COEF_W'($urandom));
			end
		end
	endtask

	initial begin
		board = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = tspd_pkg::CMD_SAMPLE;
		in_ch.sample_in = '0;
		in_ch.coef_index = '0;
		in_ch.coef_value = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = tspd_pkg::REG_TAPS_FIRST;
		cfg_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single taps, extreme coefficients and samples
		send_item(tspd_pkg::CMD_LOAD_FIRST, '0, 9'd0, 18'sh1ffff);
		send_item(tspd_pkg::CMD_LOAD_HALFBAND, '0, 9'd0, 18'sh1ffff);
		send_item(tspd_pkg::CMD_SAMPLE, 16'sh7fff, '0, '0);
		send_item(tspd_pkg::CMD_SAMPLE, 16'sh7fff, '0, '0);
		send_item(tspd_pkg::CMD_SAMPLE, 16'sh8000, '0, '0);
		send_item(tspd_pkg::CMD_SAMPLE, 16'sh8000, '0, '0);
		send_item(tspd_pkg::CMD_UNUSED, 16'sh7fff, 9'h1ff, 18'sh1ffff);
		send_item(tspd_pkg::CMD_SAMPLE, 16'sd0, '0, '0);
		send_item(tspd_pkg::CMD_SAMPLE, 16'sd1, '0, '0);
		send_item(tspd_pkg::CMD_SAMPLE, -16'sd1, '0, '0);
		send_item(tspd_pkg::CMD_LOAD_FIRST, '0, 9'd0, 18'sh20000);
		send_item(tspd_pkg::CMD_LOAD_HALFBAND, '0, 9'd0, 18'sh20000);
		send_item(tspd_pkg::CMD_LOAD_FIRST, '0, 9'h1ff, 18'sh00000);
		send_item(tspd_pkg::CMD_LOAD_HALFBAND, '0, 9'h1ff, 18'sh1ffff);
		for (int i = 0; i < 6; i++)
			send_item(tspd_pkg::CMD_SAMPLE, (i % 2) ? 16'sh8000 : 16'sh7fff, '0, '0);
		send_item(tspd_pkg::CMD_SAMPLE, 16'sh0100, '0, '0);
		send_item(tspd_pkg::CMD_SAMPLE, -16'sh0100, '0, '0);

		// Random phases across tap settings and handshake pressure
		setup_phase(7, 5);
		random_samples(90, 0);

		setup_phase(0, 0);
		send_idle_pct = 86;
		random_samples(60, 0);

		setup_phase(24, 11);
		send_idle_pct = 0;
		recv_stall_pct = 86;
		random_samples(80, 1);

		setup_phase(40, 17);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		random_samples(60, 0);

		setup_phase(2, 1);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		random_samples(40, 0);

		drain();
		if (board.expected_pcm.size() != 0) begin
			$error("%0d expected output items never arrived", board.expected_pcm.size());
			board.errors++;
		end
		$display("Fed %0d samples over tap counts 0 to 40 with idle and stall phases;",
			board.samples);
		$display("checked %0d output items, %0d of them saturated.", board.results, board.clips);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
hw/rtl/tspd_pkg.sv
hw/rtl/tspd_if.sv
hw/rtl/tspd_ram.sv
hw/rtl/three_stage_polyphase_downsampler.sv
hw/rtl/tspd_checker.sv
tb/sv/tb_three_stage_polyphase_downsampler.sv
